### design/ccg_pkg.sv
package ccg_pkg;

	localparam int TEMP_W = 12;
	localparam int CUR_W = 13;
	localparam int MV_W = 15;

	typedef enum logic [2:0] {
		ST_NOT_CHARGING = 3'd0,
		ST_PRECHARGE    = 3'd1,
		ST_CC           = 3'd2,
		ST_CV           = 3'd3,
		ST_FULL         = 3'd4,
		ST_FAULT        = 3'd5,
		ST_UNSUPPORTED  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_BCOLD = 3'd0,
		REG_BCOOL = 3'd1,
		REG_BWARM = 3'd2,
		REG_BHOT  = 3'd3,
		REG_CWARM = 3'd4,
		REG_CHOT  = 3'd5,
		REG_MAXMA = 3'd6,
		REG_CVENT = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_PREP,
		FSM_DIV1,
		FSM_MID,
		FSM_DIV2,
		FSM_FINAL,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_start;
		logic div_sel;
		logic mid;
		logic fin;
	} ccg_cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_div1;
		logic need_div2;
	} ccg_sts_t;

	typedef struct packed {
		logic               source_attached;
		logic               source_fault;
		logic               source_supports_charge;
		logic [14:0]        contract_voltage_mv;
		logic [12:0]        contract_current_ma;
		logic signed [11:0] battery_temp;
		logic signed [11:0] circuit_temp;
		logic [14:0]        battery_mv;
		logic signed [15:0] battery_ma;
		logic [6:0]         state_of_charge;
	} ccg_in_t;

	typedef struct packed {
		logic [2:0]  charge_phase;
		logic [12:0] target_current_ma;
		logic        program_current;
		logic [12:0] setpoint_ma;
		logic        inhibit_charging;
		logic        input_limit_valid;
		logic [12:0] input_limit_ma;
	} ccg_out_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] data;
	} ccg_cfg_t;

endpackage

### design/ccg_if.sv
interface ccg_in_if;
	logic             valid;
	logic             ready;
	ccg_pkg::ccg_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ccg_out_if;
	logic              valid;
	logic              ready;
	ccg_pkg::ccg_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ccg_cfg_if;
	logic              valid;
	logic              ready;
	ccg_pkg::ccg_cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/ccg_div.sv
module ccg_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] dividend,
	input  logic [31:0] divisor,
	output logic [48:0] quotient,
	output logic        done
);
	import ccg_pkg::*;

	localparam int NB = 49;

	logic [48:0] q_q;
	logic [32:0] r_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] r_sh;
	logic [32:0] r_sub;

	// restoring division, one quotient bit a cycle
	always_comb begin
		r_sh  = {r_q[31:0], q_q[48]};
		r_sub = r_sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			if (!r_sub[32]) begin
				r_q <= r_sub;
				q_q <= {q_q[47:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[47:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;
endmodule

### design/ccg_datapath.sv
module ccg_datapath #(
	parameter int MIN_CURRENT_MA = 500,
	parameter int HYSTERESIS_MA = 200,
	parameter int PRECHARGE_MV = 12000
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ccg_pkg::ccg_cmd_t cmd,
	output ccg_pkg::ccg_sts_t sts,
	input  ccg_pkg::ccg_in_t  in_item,
	input  logic              cfg_we,
	input  ccg_pkg::ccg_cfg_t cfg_item,
	output ccg_pkg::ccg_out_t result
);
	import ccg_pkg::*;

	localparam logic signed [15:0] MINC = 16'(MIN_CURRENT_MA);

	logic signed [11:0] bcold_q, bcool_q, bwarm_q, bhot_q, cwarm_q, chot_q;
	logic [12:0] maxma_q;
	logic [14:0] cvent_q;
	logic [12:0] prog_q;
	ccg_in_t     it_q;
	logic signed [15:0] cur_q;
	logic        zero_q;
	logic [1:0]  band_q;   // 0 min, 1 power, 2 hot derate
	logic        cder_q;

	logic [48:0] dvd;
	logic [31:0] dvs;
	logic [48:0] quo;
	logic        ddone;

	logic [28:0] vi_q;

	// first divide: power band or hot derating; second divide: charger derating
	logic signed [13:0] hnum, hden, cnum, cden;
	logic signed [15:0] htop, ctop;
	logic signed [31:0] hn, cn;
	logic        hneg_q, cneg_q;

	logic signed [15:0] tgt;
	logic        stop, pgm, inh;
	logic [12:0] next_prog;
	logic [2:0]  st;
	logic signed [15:0] cur_min;
	logic signed [15:0] prog_s;
	ccg_out_t    nres;

	always_comb begin
		hnum = 14'(bhot_q) - 14'(it_q.battery_temp);
		hden = 14'(bhot_q) - 14'(bwarm_q);
		htop = 16'({3'b0, maxma_q} >> 1) - MINC;
		hn   = 32'(MINC) * 32'(hden) + 32'(hnum) * 32'(htop);
		cnum = 14'(chot_q) - 14'(it_q.circuit_temp);
		cden = 14'(chot_q) - 14'(cwarm_q);
		ctop = cur_q - MINC;
		cn   = 32'(MINC) * 32'(cden) + 32'(cnum) * 32'(ctop);
		cur_min = cneg_q ? 16'sd0 : 16'(quo);
		if (!cmd.div_sel) begin
			if (band_q == 2'd1) begin
				dvd = 49'(vi_q) * 49'd17;
				dvs = 32'd20000 * 32'(it_q.battery_mv);
			end else begin
				dvd = 49'($unsigned(hn));
				dvs = 32'($unsigned(32'(hden)));
			end
		end else begin
			dvd = 49'($unsigned(cn));
			dvs = 32'($unsigned(32'(cden)));
		end
	end

	ccg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .quotient(quo), .done(ddone)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcold_q <= 12'sd0;
			bcool_q <= 12'sd100;
			bwarm_q <= 12'sd450;
			bhot_q  <= 12'sd500;
			cwarm_q <= 12'sd700;
			chot_q  <= 12'sd800;
			maxma_q <= 13'd3000;
			cvent_q <= 15'd16600;
			prog_q  <= 13'd3000;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_item.index))
					REG_BCOLD: bcold_q <= cfg_item.data[11:0];
					REG_BCOOL: bcool_q <= cfg_item.data[11:0];
					REG_BWARM: bwarm_q <= cfg_item.data[11:0];
					REG_BHOT:  bhot_q  <= cfg_item.data[11:0];
					REG_CWARM: cwarm_q <= cfg_item.data[11:0];
					REG_CHOT:  chot_q  <= cfg_item.data[11:0];
					REG_MAXMA: maxma_q <= cfg_item.data[12:0];
					REG_CVENT: cvent_q <= cfg_item.data[14:0];
					default: ;
				endcase
			end
			if (cmd.fin) prog_q <= next_prog;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) it_q <= in_item;
		if (cmd.prep) begin
			vi_q   <= 29'(it_q.contract_voltage_mv) * 29'(it_q.contract_current_ma);
			zero_q <= (it_q.battery_temp < bcold_q) || (it_q.battery_temp > bhot_q);
			if (it_q.battery_temp < bcool_q) begin
				band_q <= 2'd0;
			end else if (it_q.battery_temp <= bwarm_q) begin
				band_q <= (it_q.contract_voltage_mv != 0 && it_q.contract_current_ma != 0
					&& it_q.battery_mv != 0) ? 2'd1 : 2'd0;
			end else begin
				band_q <= 2'd2;
			end
			cur_q  <= MINC;
			cder_q <= it_q.circuit_temp > cwarm_q;
		end
		if (ddone && !cmd.div_sel) begin
			if (band_q == 2'd1)
				cur_q <= (quo > 49'(maxma_q)) ? 16'(maxma_q) : 16'(quo);
			else
				cur_q <= hneg_q ? 16'sd0 : 16'(quo);
		end
		if (ddone && cmd.div_sel) begin
			if (cur_min < cur_q) cur_q <= cur_min;
		end
		// raise a nonzero derated current to the minimum; tgt clamps to the maximum
		if (cmd.mid) begin
			if (cder_q && cur_q < MINC && cur_q != 0) cur_q <= MINC;
		end
		if (cmd.div_start) begin
			hneg_q <= hn < 0;
			cneg_q <= cn < 0;
		end
		if (cmd.fin) result <= nres;
	end

	always_comb begin
		tgt = 16'sd0;
		if (!zero_q && !(it_q.circuit_temp > chot_q))
			tgt = (cur_q > 16'(maxma_q)) ? 16'(maxma_q) : cur_q;
		prog_s = $signed({3'b0, prog_q});
		nres = '0;
		stop = 1'b0;
		pgm  = 1'b0;
		st   = ST_NOT_CHARGING;
		next_prog = prog_q;
		if (!it_q.source_attached) begin
			stop = 1'b1;
		end else if (it_q.source_fault) begin
			st = ST_FAULT; stop = 1'b1;
		end else if (!it_q.source_supports_charge) begin
			st = ST_UNSUPPORTED; stop = 1'b1;
		end else begin
			nres.input_limit_valid = 1'b1;
			nres.input_limit_ma = it_q.contract_current_ma;
			nres.target_current_ma = tgt[12:0];
			if (it_q.state_of_charge >= 7'd100) begin
				st = ST_FULL; stop = 1'b1;
			end else if (tgt == 0) begin
				stop = 1'b1;
			end else begin
				if (tgt > prog_s + 16'(HYSTERESIS_MA)
					|| tgt < prog_s - 16'(HYSTERESIS_MA)) begin
					pgm = 1'b1;
					next_prog = tgt[12:0];
				end
				if (it_q.battery_ma > 0) begin
					if (it_q.battery_mv >= cvent_q) st = ST_CV;
					else if (32'(it_q.battery_mv) < 32'(PRECHARGE_MV)) st = ST_PRECHARGE;
					else st = ST_CC;
				end
			end
		end
		inh = stop && (prog_q != 0);
		if (inh) next_prog = '0;
		nres.charge_phase = st;
		nres.program_current = pgm;
		nres.setpoint_ma = pgm ? tgt[12:0] : 13'd0;
		nres.inhibit_charging = inh;
	end

	assign sts.div_done  = ddone;
	assign sts.need_div1 = band_q != 2'd0;
	assign sts.need_div2 = cder_q;
endmodule

### design/ccg_ctrl.sv
module ccg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ccg_pkg::ccg_cmd_t cmd,
	input  ccg_pkg::ccg_sts_t sts
);
	import ccg_pkg::*;

	fsm_t state_q, state_d;
	logic ov_q;
	logic d1_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = FSM_PREP;
				end
			end
			FSM_PREP: begin
				cmd.prep = 1'b1;
				state_d = FSM_DIV1;
			end
			FSM_DIV1: begin
				// band flags are ready now; launch or skip on entry only
				if (d1_go_q) begin
					if (sts.need_div1) cmd.div_start = 1'b1;
					else state_d = FSM_MID;
				end else if (sts.div_done) begin
					state_d = FSM_MID;
				end
			end
			FSM_MID: begin
				state_d = FSM_FINAL;
				if (sts.need_div2) begin
					cmd.div_sel = 1'b1;
					cmd.div_start = 1'b1;
					state_d = FSM_DIV2;
				end
			end
			FSM_DIV2: begin
				cmd.div_sel = 1'b1;
				if (sts.div_done) state_d = FSM_FINAL;
			end
			FSM_FINAL: begin
				cmd.mid = 1'b1;
				state_d = FSM_OUT;
			end
			FSM_OUT: begin
				if (!ov_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d1_go_q <= 1'b0;
		else d1_go_q <= state_q == FSM_PREP && state_d == FSM_DIV1;
	end

	assign out_valid = ov_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == FSM_PREP) else $error("load not followed by prep");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid) else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && state_q == FSM_OUT |-> !cmd.fin)
		else $error("result overwritten");
endmodule

### design/charge_current_governor.sv
// Charge current governor: one telemetry item in, one result item out.
// The result is registered after the item passes the prep, first-divide, mid,
// second-divide, final and output states (a divide state is skipped or left at
// once when no division is needed) and waits in the output state until the
// previous result is taken; the next item can be taken in the cycle after. The
// time is set by a restoring divider shared by the power/voltage quotient, the
// hot-band derating and the charger derating. The first division runs unless
// the battery is below its cool limit or a zero voltage or current leaves it at
// the minimum current; the second runs when the charger is above its warm limit.
// Configuration writes are taken at any time and must be made while no item is
// in flight. The result sits in an output register; the next item is taken
// once the previous result has been registered.
module charge_current_governor #(
	parameter int MIN_CURRENT_MA = 500,
	parameter int HYSTERESIS_MA = 200,
	parameter int PRECHARGE_MV = 12000
) (
	input  logic clk,
	input  logic arst_n,
	ccg_in_if.sink    in_ch,
	ccg_out_if.source out_ch,
	ccg_cfg_if.sink   cfg
);
	import ccg_pkg::*;

	ccg_cmd_t cmd;
	ccg_sts_t sts;

	// registers accept every write; hold writes off while an item is in flight
	assign cfg.ready = 1'b1;

	// sequence load, band setup, the two divides and the result handoff
	ccg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	// limits, programmed current, target arithmetic and the result register
	ccg_datapath #(
		.MIN_CURRENT_MA(MIN_CURRENT_MA),
		.HYSTERESIS_MA(HYSTERESIS_MA),
		.PRECHARGE_MV(PRECHARGE_MV)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_item(in_ch.payload), .cfg_we(cfg.valid), .cfg_item(cfg.payload),
		.result(out_ch.payload)
	);
endmodule
